### design/msga_pkg.sv
// shared types and constants of the motor speed gain adapt loop
package msga_pkg;

    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned FREQ_W   = 24;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned ERR_W    = FREQ_W + 1;
    localparam int unsigned PROD_W   = FREQ_W + GAIN_W + 1;
    localparam int unsigned DRIVE_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // 1e6 us per second times 256 for the Q16.8 result
    localparam int unsigned DIVIDEND_W = 28;
    localparam logic [DIVIDEND_W-1:0] DIVIDEND = 28'd256000000;
    // periods below this give a frequency beyond the 24 bit range
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = 32'd16;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    localparam logic [1:0] RUN_THRESHOLD = 2'd3;
    localparam logic signed [DRIVE_W-1:0] DRIVE_ONE = 32'sd65536;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FREQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_ENABLE  = 3'd4;

    typedef enum logic [1:0] {
        LS_OFF    = 2'd0,
        LS_STABLE = 2'd1,
        LS_INC    = 2'd2,
        LS_DEC    = 2'd3
    } loop_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MUL,
        ST_FIN
    } fsm_state_t;

endpackage

### design/msga_in_if.sv
// input channel: one hall pulse period per item
interface msga_in_if;
    logic                            valid;
    logic                            ready;
    logic [msga_pkg::PERIOD_W-1:0]   period_us;

    modport source (output valid, output period_us, input ready);
    modport sink (input valid, input period_us, output ready);
endinterface

### design/msga_out_if.sv
// output channel: drive value, drive valid flag and loop state
interface msga_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msga_pkg::DRIVE_W-1:0]   drive_value;
    logic                                  drive_valid;
    logic [1:0]                            loop_state;

    modport source (output valid, output drive_value, output drive_valid,
                    output loop_state, input ready);
    modport sink (input valid, input drive_value, input drive_valid,
                  input loop_state, output ready);
endinterface

### design/msga_cfg_if.sv
// configuration write channel
interface msga_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [msga_pkg::CFG_IDX_W-1:0]     index;
    logic [msga_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/motor_speed_gain_adapt_loop_core.sv
// motor speed loop with adaptive integral gain, bit-serial datapath
// Each item is a hall pulse period in microseconds and gives one result item.
// With the loop enabled an item goes from acceptance to the output register
// in steps: a restoring divider forms 256e6 / period one quotient bit per cycle,
// a prep step forms the error and total gain, a shift-add multiplier takes
// one gain bit per cycle and a finish step clamps the drive and updates the
// loop state. A disabled item goes from acceptance straight to the finish step.
// A new item is taken only once the previous result is in the output
// register, so the block finishes one item before it takes the next; a full
// output register that the output side does not take holds the finish step.
// Configuration writes are taken at any time (ready is always high) and are
// meant for idle periods.
module motor_speed_gain_adapt_loop_core (
    input  logic              clk,
    input  logic              rst_n,
    msga_in_if.sink           period,
    msga_out_if.source        drive,
    msga_cfg_if.sink          cfg
);

    localparam int unsigned PW = msga_pkg::PERIOD_W;
    localparam int unsigned FW = msga_pkg::FREQ_W;
    localparam int unsigned GW = msga_pkg::GAIN_W;
    localparam int unsigned EW = msga_pkg::ERR_W;
    localparam int unsigned MW = msga_pkg::PROD_W;
    localparam int unsigned DW = msga_pkg::DRIVE_W;

    // configuration registers
    logic          enable_reg;
    logic [FW-1:0] target_reg;
    logic [GW-1:0] gain_p_reg;
    logic [GW-1:0] gain_i_step_reg;
    logic          int_en_reg;

    // sequencing
    msga_pkg::fsm_state_t state_reg, state_next;
    logic [4:0]    bit_cnt_reg;
    logic          dis_reg;
    logic          sat_reg;

    // divider
    logic [PW-1:0] divisor_reg;
    logic [PW-1:0] rem_reg;
    logic [FW-1:0] quo_reg;
    logic [PW:0]   rem_shift;
    logic          quo_bit;

    // multiplier
    logic signed [EW-1:0] err_reg;
    logic [FW-1:0] mag_reg;
    logic [GW:0]   mul_reg;
    logic [MW-1:0] acc_reg;
    logic [FW:0]   acc_add;

    // loop state
    logic signed [EW-1:0] prev_err_reg;
    logic [GW-1:0] integral_reg;
    logic [1:0]    neg_cnt_reg;

    // output register
    logic                  out_valid_reg;
    logic signed [DW-1:0]  drive_reg;
    logic                  dvalid_reg;
    msga_pkg::loop_state_t lstate_reg;

    // fsm outputs
    logic period_ready;
    logic fin_load;

    // finish stage
    logic [FW-1:0]        freq;
    logic signed [EW-1:0] err_calc;
    logic [MW-8:0]        pos_v;
    logic [MW:0]          neg_sum;
    logic [MW-8:0]        neg_t;
    logic signed [DW-1:0] drive_calc;
    logic                 err_pos, err_neg, prev_pos, prev_neg;
    logic [GW:0]          isum;
    logic [1:0]           cnt_inc;

    assign period.ready  = period_ready;
    assign cfg.ready     = 1'b1;
    assign drive.valid       = out_valid_reg;
    assign drive.drive_value = drive_reg;
    assign drive.drive_valid = dvalid_reg;
    assign drive.loop_state  = lstate_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            target_reg      <= '0;
            gain_p_reg      <= '0;
            gain_i_step_reg <= '0;
            int_en_reg      <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                msga_pkg::CFG_ENABLE:      enable_reg      <= cfg.data[0];
                msga_pkg::CFG_TARGET_FREQ: target_reg      <= cfg.data[FW-1:0];
                msga_pkg::CFG_GAIN_P:      gain_p_reg      <= cfg.data[GW-1:0];
                msga_pkg::CFG_GAIN_I_STEP: gain_i_step_reg <= cfg.data[GW-1:0];
                msga_pkg::CFG_INT_ENABLE:  int_en_reg      <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msga_pkg::ST_IDLE:
            begin
                if (period.valid)
                    state_next = enable_reg ? msga_pkg::ST_DIV : msga_pkg::ST_FIN;
            end
            msga_pkg::ST_DIV:
            begin
                if (bit_cnt_reg == 5'd0)
                    state_next = msga_pkg::ST_PREP;
            end
            msga_pkg::ST_PREP: state_next = msga_pkg::ST_MUL;
            msga_pkg::ST_MUL:
            begin
                if (bit_cnt_reg == 5'd0)
                    state_next = msga_pkg::ST_FIN;
            end
            msga_pkg::ST_FIN:
            begin
                if (!out_valid_reg || drive.ready)
                    state_next = msga_pkg::ST_IDLE;
            end
            default: state_next = msga_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        period_ready = 1'b0;
        fin_load     = 1'b0;
        unique case (state_reg)
            msga_pkg::ST_IDLE: period_ready = 1'b1;
            msga_pkg::ST_FIN:  fin_load = !out_valid_reg || drive.ready;
            default: ;
        endcase
    end

    // divider step: one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, msga_pkg::DIVIDEND[bit_cnt_reg]};
        quo_bit   = rem_shift >= {1'b0, divisor_reg};
    end

    // multiplier step: one gain bit per cycle, product shifts right
    assign acc_add = {1'b0, acc_reg[MW-1:GW+1]} + (mul_reg[0] ? {1'b0, mag_reg} : '0);

    assign freq     = sat_reg ? msga_pkg::FREQ_MAX : quo_reg;
    assign err_calc = $signed({1'b0, target_reg}) - $signed({1'b0, freq});

    // drive clamp: floor toward minus infinity for negative errors
    always_comb
    begin
        pos_v   = {1'b0, acc_reg[MW-1:8]};
        neg_sum = {1'b0, acc_reg} + (MW+1)'(255);
        neg_t   = neg_sum[MW:8];
        if (dis_reg)
            drive_calc = '0;
        else if (err_reg[EW-1])
        begin
            if (neg_t >= (MW-7)'(64'h8000_0000))
                drive_calc = msga_pkg::DRIVE_MIN;
            else
                drive_calc = -$signed(neg_t[DW-1:0]);
        end
        else
        begin
            if (pos_v > (MW-7)'(msga_pkg::DRIVE_ONE))
                drive_calc = msga_pkg::DRIVE_ONE;
            else
                drive_calc = $signed(pos_v[DW-1:0]);
        end
    end

    assign err_pos  = !err_reg[EW-1] && (err_reg != '0);
    assign err_neg  = err_reg[EW-1];
    assign prev_pos = !prev_err_reg[EW-1] && (prev_err_reg != '0);
    assign prev_neg = prev_err_reg[EW-1];
    assign isum     = {1'b0, integral_reg} + {1'b0, gain_i_step_reg};
    assign cnt_inc  = (neg_cnt_reg == 2'd3) ? 2'd3 : neg_cnt_reg + 2'd1;

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msga_pkg::ST_IDLE;
            bit_cnt_reg   <= '0;
            dis_reg       <= 1'b0;
            prev_err_reg  <= '0;
            integral_reg  <= '0;
            neg_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            lstate_reg    <= msga_pkg::LS_OFF;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                msga_pkg::ST_IDLE:
                begin
                    if (period.valid)
                    begin
                        dis_reg     <= !enable_reg;
                        divisor_reg <= period.period_us;
                        sat_reg     <= period.period_us < msga_pkg::MIN_PERIOD;
                        rem_reg     <= '0;
                        bit_cnt_reg <= 5'(msga_pkg::DIVIDEND_W - 1);
                    end
                end
                msga_pkg::ST_DIV:
                begin
                    rem_reg     <= quo_bit ? rem_shift[PW-1:0] - divisor_reg
                                           : rem_shift[PW-1:0];
                    quo_reg     <= {quo_reg[FW-2:0], quo_bit};
                    bit_cnt_reg <= bit_cnt_reg - 5'd1;
                end
                msga_pkg::ST_PREP:
                begin
                    err_reg     <= err_calc;
                    mag_reg     <= err_calc[EW-1] ? FW'(-err_calc) : err_calc[FW-1:0];
                    mul_reg     <= {1'b0, gain_p_reg} + {1'b0, integral_reg};
                    acc_reg     <= '0;
                    bit_cnt_reg <= 5'(GW);
                end
                msga_pkg::ST_MUL:
                begin
                    acc_reg     <= {acc_add, acc_reg[GW:1]};
                    mul_reg     <= {1'b0, mul_reg[GW:1]};
                    bit_cnt_reg <= bit_cnt_reg - 5'd1;
                end
                msga_pkg::ST_FIN:
                begin
                    if (fin_load)
                    begin
                        drive_reg  <= drive_calc;
                        dvalid_reg <= !dis_reg;
                        if (dis_reg)
                            lstate_reg <= msga_pkg::LS_OFF;
                        else
                        begin
                            prev_err_reg <= err_reg;
                            if (prev_pos && err_pos)
                            begin
                                if (int_en_reg)
                                    integral_reg <= isum[GW] ? '1 : isum[GW-1:0];
                                neg_cnt_reg <= 2'd0;
                                lstate_reg  <= msga_pkg::LS_INC;
                            end
                            else if (prev_neg && err_neg)
                            begin
                                neg_cnt_reg <= cnt_inc;
                                lstate_reg  <= (cnt_inc >= msga_pkg::RUN_THRESHOLD)
                                               ? msga_pkg::LS_DEC : msga_pkg::LS_STABLE;
                                if (int_en_reg)
                                    integral_reg <= (integral_reg > gain_i_step_reg)
                                                    ? integral_reg - gain_i_step_reg : '0;
                            end
                            else
                                lstate_reg <= msga_pkg::LS_STABLE;
                        end
                    end
                end
                default: ;
            endcase

            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (drive.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // an enabled item goes straight into the divider
    a_enabled_item_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (period.valid && period.ready && enable_reg) |=> state_reg == msga_pkg::ST_DIV)
        else $error("enabled item did not start division");

    // a disabled result always reports the off state
    a_off_when_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && !drive.drive_valid) |-> drive.loop_state == msga_pkg::LS_OFF)
        else $error("result without drive not reported off");

    // drive never exceeds full scale
    a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |-> drive.drive_value <= msga_pkg::DRIVE_ONE)
        else $error("drive above full scale");

    // the input side is closed while an item is being worked on
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msga_pkg::ST_MUL || state_reg == msga_pkg::ST_DIV) |-> !period.ready)
        else $error("input ready while an item is in progress");

endmodule

### tb/msga_loop_checker.sv
// checker for the speed loop: predicts each drive item and compares it with the output channel
module msga_loop_checker (
    input  logic        clk,
    input  logic        rst_n,
    msga_in_if          period_ch,
    msga_out_if         drive_ch,
    msga_cfg_if         cfg_ch,
    output int unsigned outstanding,
    output int unsigned mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    // 1e6 us per second in Q16.8
    localparam logic [msga_pkg::PERIOD_W-1:0] SPEED_SCALE = 32'd256000000;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef struct packed {
        logic signed [msga_pkg::DRIVE_W-1:0] drive_value;
        logic                                drive_valid;
        msga_pkg::loop_state_t               loop_state;
    } drive_result_t;

    // register copies
    logic                        run_on;
    logic [msga_pkg::FREQ_W-1:0] target_hz;
    logic [msga_pkg::GAIN_W-1:0] gain_fixed;
    logic [msga_pkg::GAIN_W-1:0] gain_step;
    logic                        adapt_on;

    // loop state
    logic signed [msga_pkg::ERR_W-1:0] prev_err;
    logic [msga_pkg::GAIN_W-1:0]       integ_gain;
    logic [1:0]                        neg_run;
    msga_pkg::loop_state_t             trend;

    drive_result_t pending_drives [$];

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic drive_result_t predict_drive(
        input logic [msga_pkg::PERIOD_W-1:0] period_us);
        drive_result_t                 res;
        logic [msga_pkg::PERIOD_W-1:0] quot;
        logic [msga_pkg::FREQ_W-1:0]   speed;
        int                            err;
        logic [msga_pkg::GAIN_W:0]     gain;
        logic [msga_pkg::GAIN_W:0]     bumped;
        longint                        prod;
        res.drive_value = '0;
        res.drive_valid = 1'b0;
        res.loop_state  = msga_pkg::LS_OFF;
        if (!run_on)
        begin
            trend = msga_pkg::LS_OFF;
            return res;
        end
        if (period_us == '0)
            speed = msga_pkg::FREQ_MAX;
        else
        begin
            quot  = SPEED_SCALE / period_us;
            speed = (quot > {8'd0, msga_pkg::FREQ_MAX}) ? msga_pkg::FREQ_MAX
                                                        : quot[msga_pkg::FREQ_W-1:0];
        end
        err  = int'(target_hz) - int'(speed);
        gain = {1'b0, gain_fixed} + {1'b0, integ_gain};
        // arithmetic shift floors the q24.24 product toward minus infinity
        prod = (longint'(err) * longint'(gain)) >>> 8;
        if (prod > longint'(msga_pkg::DRIVE_ONE))
            prod = longint'(msga_pkg::DRIVE_ONE);
        if (prod < longint'(msga_pkg::DRIVE_MIN))
            prod = longint'(msga_pkg::DRIVE_MIN);
        res.drive_value = prod[msga_pkg::DRIVE_W-1:0];
        res.drive_valid = 1'b1;

        if (prev_err > 0 && err > 0)
        begin
            if (adapt_on)
            begin
                bumped     = {1'b0, integ_gain} + {1'b0, gain_step};
                integ_gain = bumped[msga_pkg::GAIN_W] ? '1 : bumped[msga_pkg::GAIN_W-1:0];
            end
            neg_run = '0;
            trend   = msga_pkg::LS_INC;
        end
        else if (prev_err < 0 && err < 0)
        begin
            if (neg_run != '1)
                neg_run = neg_run + 2'd1;
            trend = (neg_run >= msga_pkg::RUN_THRESHOLD) ? msga_pkg::LS_DEC
                                                         : msga_pkg::LS_STABLE;
            if (adapt_on)
                integ_gain = (integ_gain > gain_step) ? integ_gain - gain_step : '0;
        end
        else
            trend = msga_pkg::LS_STABLE;
        prev_err       = err[msga_pkg::ERR_W-1:0];
        res.loop_state = trend;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_result_t want;
        if (!rst_n)
        begin
            run_on      = 1'b0;
            target_hz   = '0;
            gain_fixed  = '0;
            gain_step   = '0;
            adapt_on    = 1'b1;
            prev_err    = '0;
            integ_gain  = '0;
            neg_run     = '0;
            trend       = msga_pkg::LS_OFF;
            mismatches  = 0;
            pending_drives.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    msga_pkg::CFG_ENABLE:      run_on     = cfg_ch.data[0];
                    msga_pkg::CFG_TARGET_FREQ:
                        target_hz  = cfg_ch.data[msga_pkg::FREQ_W-1:0];
                    msga_pkg::CFG_GAIN_P:
                        gain_fixed = cfg_ch.data[msga_pkg::GAIN_W-1:0];
                    msga_pkg::CFG_GAIN_I_STEP:
                        gain_step  = cfg_ch.data[msga_pkg::GAIN_W-1:0];
                    msga_pkg::CFG_INT_ENABLE:  adapt_on   = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (drive_ch.valid && drive_ch.ready)
            begin
                if (pending_drives.size() == 0)
                    report_mismatch("drive item with none expected");
                else
                begin
                    want = pending_drives.pop_front();
                    if (drive_ch.drive_value !== want.drive_value)
                        report_mismatch($sformatf("drive_value %0d, expected %0d",
                                                  drive_ch.drive_value, want.drive_value));
                    if (drive_ch.drive_valid !== want.drive_valid)
                        report_mismatch($sformatf("drive_valid %b, expected %b",
                                                  drive_ch.drive_valid, want.drive_valid));
                    if (drive_ch.loop_state !== want.loop_state)
                        report_mismatch($sformatf("loop_state %0d, expected %0d",
                                                  drive_ch.loop_state, want.loop_state));
                end
            end
            if (period_ch.valid && period_ch.ready)
                pending_drives.push_back(predict_drive(period_ch.period_us));
            outstanding <= pending_drives.size();
        end
    end

endmodule

### tb/tb.sv
// top of the speed loop testbench: clock, reset, stimulus, output stalls and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT     = 4000;
    localparam int unsigned SQUEEZE_CYCLES  = 500;
    localparam int unsigned RAND_PHASES     = 12;
    localparam int unsigned ITEMS_PER_PHASE = 165;
    localparam int unsigned TAIL_CYCLES     = 120;
    localparam logic [msga_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO =
        msga_pkg::CFG_INT_ENABLE + 3'd1;

    logic clk = 1'b0;
    logic rst_n;

    msga_in_if  period_ch ();
    msga_out_if drive_ch ();
    msga_cfg_if cfg_ch ();

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned idle_cycles;

    bit tx_calm;
    bit rx_calm;
    bit squeeze_phase;
    bit squeeze_done;

    // target 256 Hz: zero period, saturating speeds, a negative run, positive repeats, then a second negative run
    logic [msga_pkg::PERIOD_W-1:0] opening_periods [0:16] = '{
        32'd0, 32'd1, 32'd15, 32'd16, 32'd17, 32'd3906, 32'd3907, 32'd4000,
        32'd5000, 32'd1000000, 32'd256000000, 32'd256000001, 32'hFFFF_FFFF,
        32'd3906, 32'd100, 32'd50, 32'd20
    };

    motor_speed_gain_adapt_loop_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .period (period_ch),
        .drive  (drive_ch),
        .cfg    (cfg_ch)
    );

    msga_loop_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .period_ch   (period_ch),
        .drive_ch    (drive_ch),
        .cfg_ch      (cfg_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    function automatic logic [msga_pkg::GAIN_W-1:0] pick_reg();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return msga_pkg::GAIN_W'($urandom_range(1, 4095));
            default: return msga_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    // slow periods give a speed below target, i.e. a positive error
    function automatic logic [msga_pkg::PERIOD_W-1:0] pick_period(
        input bit slow, input logic [msga_pkg::FREQ_W-1:0] tgt);
        logic [msga_pkg::PERIOD_W-1:0] thr;
        int unsigned                   r;
        thr = (tgt == '0) ? '0 : 32'd256000000 / {8'd0, tgt} + 32'd1;
        r   = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return $urandom_range(0, 20);
        if (slow)
        begin
            if (thr == '0)
                return $urandom;
            return thr + $urandom_range(0, thr);
        end
        if (thr <= 32'd1)
            return $urandom_range(1, 15);
        return $urandom_range(1, thr - 32'd1);
    endfunction

    task automatic send_period(input logic [msga_pkg::PERIOD_W-1:0] p);
        int unsigned gap;
        gap = idle_len(tx_calm);
        if (gap > 0)
        begin
            period_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        period_ch.valid     <= 1'b1;
        period_ch.period_us <= p;
        @(posedge clk);
        while (!period_ch.ready)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [msga_pkg::CFG_IDX_W-1:0] idx,
                             input logic [msga_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // stop offering items and wait until every drive item is back
    task automatic settle();
        period_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic apply_setup(input bit en, input logic [msga_pkg::FREQ_W-1:0] tgt,
                               input logic [msga_pkg::GAIN_W-1:0] gp,
                               input logic [msga_pkg::GAIN_W-1:0] gs,
                               input bit adapt);
        logic [msga_pkg::CFG_DATA_W-1:0] en_word;
        logic [msga_pkg::CFG_DATA_W-1:0] adapt_word;
        // upper bits of the one-bit registers carry junk
        en_word       = msga_pkg::CFG_DATA_W'($urandom);
        en_word[0]    = en;
        adapt_word    = msga_pkg::CFG_DATA_W'($urandom);
        adapt_word[0] = adapt;
        cfg_write(msga_pkg::CFG_TARGET_FREQ, tgt);
        cfg_write(msga_pkg::CFG_GAIN_P, gp);
        cfg_write(msga_pkg::CFG_GAIN_I_STEP, gs);
        cfg_write(msga_pkg::CFG_INT_ENABLE, adapt_word);
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_UNUSED_LO + msga_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                      msga_pkg::CFG_DATA_W'($urandom));
        cfg_write(msga_pkg::CFG_ENABLE, en_word);
        cfg_ch.valid <= 1'b0;
    endtask

    // output side: random stalls, plus one long hold-off while the input keeps coming
    initial
    begin
        int unsigned stall;
        drive_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_phase && !squeeze_done)
            begin
                drive_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                stall = idle_len(rx_calm);
                if (stall > 0)
                begin
                    drive_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            drive_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (period_ch.valid && period_ch.ready) ||
            (drive_ch.valid && drive_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned                 ph;
        int unsigned                 n;
        int unsigned                 run;
        bit                          slow;
        bit                          en;
        bit                          adapt;
        logic [msga_pkg::FREQ_W-1:0] tgt;
        logic [msga_pkg::GAIN_W-1:0] gp;
        logic [msga_pkg::GAIN_W-1:0] gs;

        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        squeeze_phase       = 1'b0;
        squeeze_done        = 1'b0;
        period_ch.valid     = 1'b0;
        period_ch.period_us = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = msga_pkg::CFG_ENABLE;
        cfg_ch.data         = '0;
        rst_n               = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // loop is off after reset
        send_period(32'd1);
        send_period(32'hFFFF_FFFF);
        settle();

        apply_setup(1'b1, 24'h010000, 24'h010000, 24'h000100, 1'b1);
        foreach (opening_periods[i])
            send_period(opening_periods[i]);
        settle();

        // integral frozen, junk in the upper enable bits
        cfg_write(msga_pkg::CFG_INT_ENABLE, 24'hFFFFFE);
        cfg_write(CFG_UNUSED_LO, 24'hFFFFFF);
        cfg_write(msga_pkg::CFG_ENABLE, 24'hFFFFFF);
        cfg_ch.valid <= 1'b0;
        send_period(32'd5000);
        send_period(32'd6000);
        send_period(32'h8000_0000);
        settle();

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            en    = 1'b1;
            adapt = 1'b1;
            case (ph)
                0:
                begin
                    tgt = '1;
                    gp  = '1;
                    gs  = '1;
                end
                1:
                begin
                    tgt = '0;
                    gp  = '0;
                    gs  = '0;
                end
                default:
                begin
                    tgt   = pick_reg();
                    gp    = pick_reg();
                    gs    = pick_reg();
                    en    = (ph != 5);
                    adapt = (ph != 8);
                end
            endcase
            apply_setup(en, tgt, gp, gs, adapt);
            rx_calm       = (ph % 4 == 2);
            tx_calm       = (ph % 4 == 2) || (ph == 3);
            squeeze_phase = (ph == 3);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                slow = $urandom_range(0, 1);
                run  = $urandom_range(1, 8);
                repeat (run)
                begin
                    send_period(pick_period(slow, tgt));
                    n++;
                end
            end
            squeeze_phase = 1'b0;
            settle();
        end

        rx_calm = 1'b0;
        tx_calm = 1'b0;
        // catch any stray drive item after the last one expected
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
